// ===== design/ohl_pkg.sv =====
// ----------------------------------------------------------------------------
// ohl_pkg
// Request/result payload types, command codes and controller/datapath
// command struct for the ordered handle list.
// ----------------------------------------------------------------------------
package ohl_pkg;

    localparam int CMD_W    = 3;
    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HAS    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] item_handle;
    } t_in;

    typedef struct packed {
        logic                status;
        logic                found;
        logic [HANDLE_W-1:0] cursor_handle;
        logic [COUNT_W-1:0]  entry_count;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request, register per-cell match vector
        logic apply;  // commit list/cursor update and load result register
    } t_dp_cmd;

endpackage

// ===== design/ohl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ohl_ctrl
// Two-state sequencer: accept a request, then commit it once the result
// register is free. Owns both handshakes.
// ----------------------------------------------------------------------------
module ohl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ohl_pkg::t_dp_cmd o_dp_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic load, apply;

    assign load  = (r_state == S_IDLE) && i_in_valid;
    assign apply = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (load) n_state = S_UPD;
            end
            S_UPD: begin
                if (apply) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (apply)
            n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_dp_cmd.load  = load;
    assign o_dp_cmd.apply = apply;

endmodule

// ===== design/ohl_dpath.sv =====
// ----------------------------------------------------------------------------
// ohl_dpath
// Row of handle cells with parallel compare, shift compaction on remove,
// cursor registers and the result register.
// ----------------------------------------------------------------------------
module ohl_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ohl_pkg::t_dp_cmd i_dp_cmd,
    input  ohl_pkg::t_in     i_req,
    output ohl_pkg::t_out    o_res
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = ohl_pkg::HANDLE_W;

    logic [HW-1:0]             r_cell [CAPACITY];
    logic [CW-1:0]             r_count, n_count;
    logic [PW-1:0]             r_pos, n_pos;
    logic                      r_cur_valid, n_cur_valid;
    logic [HW-1:0]             r_cur_handle, n_cur_handle;
    logic [ohl_pkg::CMD_W-1:0] r_cmd;
    logic [HW-1:0]             r_handle;
    logic [CAPACITY-1:0]       r_match;
    ohl_pkg::t_out             r_res;

    logic [CAPACITY-1:0] match_in;
    logic [CAPACITY-1:0] prefix;   // at or after the first match
    logic [CAPACITY-1:0] first;    // first match, one-hot
    logic                any_hit;
    logic [PW-1:0]       pos_p1;
    logic [CW-1:0]       pos_p1_c;
    logic                do_append, do_shift;
    logic                st, fnd;
    logic [31:0]         count32;

    // compare against the incoming handle; only live cells take part
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_in[i] = (r_cell[i] == i_req.item_handle) && (CW'(i) < r_count)
                          && (i_req.item_handle != '0);
        end
    end

    assign first    = r_match & (~r_match + 1'b1);
    assign prefix   = r_match | (~r_match + 1'b1);
    assign any_hit  = |r_match;
    assign pos_p1   = r_pos + 1'b1;
    assign pos_p1_c = CW'(r_pos) + CW'(1);

    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_cur_valid  = r_cur_valid;
        n_cur_handle = r_cur_handle;
        do_append    = 1'b0;
        do_shift     = 1'b0;
        st           = 1'b0;
        fnd          = 1'b0;
        case (r_cmd)
            ohl_pkg::CMD_APPEND: begin
                if (r_handle != '0 && r_count < CW'(CAPACITY)) begin
                    do_append = 1'b1;
                    n_count   = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_pos        = '0;
                        n_cur_valid  = 1'b1;
                        n_cur_handle = r_handle;
                    end
                end else begin
                    st = 1'b1;
                end
            end
            ohl_pkg::CMD_REMOVE: begin
                if (any_hit) begin
                    do_shift = 1'b1;
                    n_count  = r_count - 1'b1;
                    if (r_cur_valid) begin
                        if (first[r_pos]) begin
                            if (pos_p1_c >= r_count)
                                n_cur_valid = 1'b0;
                            else
                                n_cur_handle = r_cell[pos_p1];
                        end else if (prefix[r_pos]) begin
                            n_pos = r_pos - 1'b1;
                        end
                    end
                end else begin
                    st = 1'b1;
                end
            end
            ohl_pkg::CMD_HAS: begin
                fnd = any_hit;
            end
            ohl_pkg::CMD_HEAD: begin
                n_pos        = '0;
                n_cur_valid  = (r_count != '0);
                n_cur_handle = r_cell[0];
                st           = (r_count == '0);
            end
            ohl_pkg::CMD_NEXT: begin
                if (!r_cur_valid) begin
                    st = 1'b1;
                end else if (pos_p1_c < r_count) begin
                    n_pos        = pos_p1;
                    n_cur_handle = r_cell[pos_p1];
                end else begin
                    n_cur_valid = 1'b0;
                    st          = 1'b1;
                end
            end
            ohl_pkg::CMD_PEEK: begin
                st = !r_cur_valid;
            end
            default: begin
                st = 1'b1;
            end
        endcase
    end

    assign count32 = 32'(n_count);

    // cells: append writes at the tail, remove pulls each later cell down by one
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_dp_cmd.apply) begin
                if (do_append && CW'(g) == r_count) begin
                    r_cell[g] <= r_handle;
                end else if (do_shift && prefix[g]) begin
                    if (g < CAPACITY - 1) r_cell[g] <= r_cell[(g + 1) % CAPACITY];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pos       <= '0;
            r_cur_valid <= 1'b0;
        end else if (i_dp_cmd.apply) begin
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_cur_valid <= n_cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd    <= i_req.cmd;
            r_handle <= i_req.item_handle;
            r_match  <= match_in;
        end
        if (i_dp_cmd.apply) begin
            r_cur_handle        <= n_cur_handle;
            r_res.status        <= st;
            r_res.found         <= fnd;
            r_res.cursor_handle <= n_cur_valid ? n_cur_handle : '0;
            r_res.entry_count   <= count32[ohl_pkg::COUNT_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

// ===== design/ordered_handle_list_with_cursor.sv =====
// ----------------------------------------------------------------------------
// ordered_handle_list_with_cursor
// Ordered list of nonzero handles with delete and a cursor.
// ----------------------------------------------------------------------------
// On the accepting edge every cell compares its handle with the request in
// parallel and the hit vector is registered. Once the result register is
// free, the list, cursor and result register are updated; remove closes
// the gap by shifting every later cell down one place. Only one request
// is in flight at a time, so a new request is taken only after the last
// one has been committed. The update waits while an earlier result is
// still held stalled in the result register, and the request side stays
// stalled for as long as it waits. There is no clearing pass after reset.
// entry_count carries the low 5 bits of the count.
module ordered_handle_list_with_cursor #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request channel
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ohl_pkg::t_in  i_in_data,
    // result channel
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ohl_pkg::t_out o_out_data
);

    ohl_pkg::t_dp_cmd dp_cmd;

    // sequencer: handshakes and load/apply strobes
    ohl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (dp_cmd)
    );

    // cell row, cursor and result register
    ohl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dp_cmd (dp_cmd),
        .i_req    (i_in_data),
        .o_res    (o_out_data)
    );

endmodule

// ===== design/ohl_checker.sv =====
// ----------------------------------------------------------------------------
// ohl_checker
// Port-level checks for the ordered handle list, bound to the top level.
// ----------------------------------------------------------------------------
module ohl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ohl_pkg::t_out o_out_data
);

    // stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // one request at a time: stall right after an accepted request
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // a result follows every request accepted while no result is held
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> ##1 o_out_valid)
        else $error("no result after request");

    // a membership hit is never an error
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> !o_out_data.status)
        else $error("found with error status");

endmodule

bind ordered_handle_list_with_cursor ohl_checker u_ohl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
